// ===== rtl/core/tss_pkg.sv =====
package tss_pkg;

  // Field widths
  localparam int CoordWidth    = 7;
  localparam int ProdWidth     = 2 * CoordWidth;
  localparam int AddrWidth     = 16;
  localparam int StrideWidth   = 8;
  localparam int RowProdWidth  = CoordWidth + StrideWidth;
  localparam int CfgIndexWidth = 4;
  localparam int CfgDataWidth  = 16;

  // Register reset values
  localparam logic [AddrWidth-1:0]   FrameBaseReset = AddrWidth'(40960);
  localparam logic [StrideWidth-1:0] RowStrideReset = StrideWidth'(40);

  // Register indexes on the config port
  typedef enum logic [CfgIndexWidth-1:0] {
    CfgFrameBase = CfgIndexWidth'(0),
    CfgRowStride = CfgIndexWidth'(1)
  } cfg_reg_e;

  typedef logic [CoordWidth-1:0] coord_t;

  // Input item
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t row;
  } span_in_t;

  // Result item
  typedef struct packed {
    logic                 covered;
    coord_t               left_x;
    coord_t               right_x;
    logic [AddrWidth-1:0] start_address;
  } span_out_t;

  // One edge after setup: |dx| * num / den, applied to x0 with sign neg
  typedef struct packed {
    logic   flat;
    logic   neg;
    coord_t x0;
    coord_t x1;
    coord_t mag;
    coord_t num;
    coord_t den;
  } setup_lane_t;

  typedef struct packed {
    logic        covered;
    coord_t      row;
    setup_lane_t la;
    setup_lane_t lb;
  } setup_t;

  // One edge inside the divider: acc holds {remainder, numerator/quotient bits}
  typedef struct packed {
    logic                 flat;
    logic                 neg;
    coord_t               x0;
    coord_t               x1;
    coord_t               den;
    logic [ProdWidth-1:0] acc;
  } div_lane_t;

  typedef struct packed {
    logic                 covered;
    logic [AddrWidth-1:0] addr_row;
    div_lane_t            la;
    div_lane_t            lb;
  } div_t;

endpackage

// ===== rtl/core/tss_setup.sv =====
module tss_setup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tss_pkg::span_in_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tss_pkg::setup_t   data_o
);

  tss_pkg::coord_t sx [3];
  tss_pkg::coord_t sy [3];
  tss_pkg::coord_t tmp_x;
  tss_pkg::coord_t tmp_y;
  tss_pkg::setup_t data_d;
  tss_pkg::setup_t data_q;
  logic            valid_q;

  function automatic tss_pkg::setup_lane_t mk_lane(tss_pkg::coord_t x0, tss_pkg::coord_t x1,
                                                   tss_pkg::coord_t num, tss_pkg::coord_t den);
    tss_pkg::setup_lane_t l;
    l.flat = (den == '0);
    l.neg  = (x1 < x0);
    l.mag  = l.neg ? (x0 - x1) : (x1 - x0);
    l.x0   = x0;
    l.x1   = x1;
    l.num  = num;
    l.den  = den;
    return l;
  endfunction

  // Stable sort by y: four passes of a single compare-swap each
  always_comb begin
    sx[0] = data_i.ax;
    sy[0] = data_i.ay;
    sx[1] = data_i.bx;
    sy[1] = data_i.by;
    sx[2] = data_i.cx;
    sy[2] = data_i.cy;
    tmp_x = '0;
    tmp_y = '0;
    for (int p = 0; p < 4; p++) begin
      if (sy[0] > sy[1]) begin
        tmp_x = sx[0]; sx[0] = sx[1]; sx[1] = tmp_x;
        tmp_y = sy[0]; sy[0] = sy[1]; sy[1] = tmp_y;
      end else if (sy[1] > sy[2]) begin
        tmp_x = sx[1]; sx[1] = sx[2]; sx[2] = tmp_x;
        tmp_y = sy[1]; sy[1] = sy[2]; sy[2] = tmp_y;
      end
    end
  end

  // Pick both edges crossing the row, upper or lower half
  always_comb begin
    data_d.covered = (data_i.row >= sy[0]) && (data_i.row <= sy[2]);
    data_d.row     = data_i.row;
    if (data_i.row <= sy[1]) begin
      data_d.la = mk_lane(sx[0], sx[1], data_i.row - sy[0], sy[1] - sy[0]);
      data_d.lb = mk_lane(sx[0], sx[2], data_i.row - sy[0], sy[2] - sy[0]);
    end else begin
      data_d.la = mk_lane(sx[2], sx[1], sy[2] - data_i.row, sy[2] - sy[1]);
      data_d.lb = mk_lane(sx[2], sx[0], sy[2] - data_i.row, sy[2] - sy[0]);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/tss_mul.sv =====
module tss_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tss_pkg::AddrWidth-1:0]      frame_base_i,
  input  logic [tss_pkg::StrideWidth-1:0]    row_stride_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  tss_pkg::setup_t                    data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output tss_pkg::div_t                      data_o
);

  logic [tss_pkg::ProdWidth-1:0]    prod_a;
  logic [tss_pkg::ProdWidth-1:0]    prod_b;
  logic [tss_pkg::RowProdWidth-1:0] row_prod;
  tss_pkg::div_t                    data_d;
  tss_pkg::div_t                    data_q;
  logic                             valid_q;

  // Edge numerators |dx| * dy and the row offset
  assign prod_a   = tss_pkg::ProdWidth'(data_i.la.mag) * tss_pkg::ProdWidth'(data_i.la.num);
  assign prod_b   = tss_pkg::ProdWidth'(data_i.lb.mag) * tss_pkg::ProdWidth'(data_i.lb.num);
  assign row_prod = tss_pkg::RowProdWidth'(data_i.row) * tss_pkg::RowProdWidth'(row_stride_i);

  always_comb begin
    data_d.covered  = data_i.covered;
    data_d.addr_row = frame_base_i + tss_pkg::AddrWidth'(row_prod);
    data_d.la.flat  = data_i.la.flat;
    data_d.la.neg   = data_i.la.neg;
    data_d.la.x0    = data_i.la.x0;
    data_d.la.x1    = data_i.la.x1;
    data_d.la.den   = data_i.la.den;
    data_d.la.acc   = prod_a;
    data_d.lb.flat  = data_i.lb.flat;
    data_d.lb.neg   = data_i.lb.neg;
    data_d.lb.x0    = data_i.lb.x0;
    data_d.lb.x1    = data_i.lb.x1;
    data_d.lb.den   = data_i.lb.den;
    data_d.lb.acc   = prod_b;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/tss_div.sv =====
module tss_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tss_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tss_pkg::div_t data_o
);

  localparam int W = tss_pkg::CoordWidth;

  logic          vld_q [W];
  tss_pkg::div_t st_q  [W];
  logic [W:0]    rdy;

  // One restoring step: shift in a numerator bit, subtract if it fits
  function automatic tss_pkg::div_lane_t lane_step(tss_pkg::div_lane_t l);
    logic [W:0]         t;
    logic               ge;
    tss_pkg::div_lane_t r;
    r  = l;
    t  = {l.acc[tss_pkg::ProdWidth-1:W], l.acc[W-1]};
    ge = (t >= {1'b0, l.den});
    r.acc[tss_pkg::ProdWidth-1:W] = ge ? W'(t - {1'b0, l.den}) : t[W-1:0];
    r.acc[W-1:0]                  = {l.acc[W-2:0], ge};
    return r;
  endfunction

  function automatic tss_pkg::div_t div_step(tss_pkg::div_t d);
    tss_pkg::div_t r;
    r    = d;
    r.la = lane_step(d.la);
    r.lb = lane_step(d.lb);
    return r;
  endfunction

  assign rdy[W] = ready_i;

  // One quotient bit per stage for both edges
  for (genvar s = 0; s < W; s++) begin : g_stage
    tss_pkg::div_t src;
    logic          src_v;

    if (s == 0) begin : g_first
      assign src   = data_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[s-1];
      assign src_v = vld_q[s-1];
    end

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_v) begin
        st_q[s] <= div_step(src);
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[W-1];
  assign data_o  = st_q[W-1];

endmodule

// ===== rtl/core/tss_span.sv =====
module tss_span (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  tss_pkg::div_t      data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output tss_pkg::span_out_t data_o
);

  localparam int W = tss_pkg::CoordWidth;

  tss_pkg::coord_t    xa;
  tss_pkg::coord_t    xb;
  tss_pkg::coord_t    lo;
  tss_pkg::coord_t    hi;
  tss_pkg::span_out_t data_d;
  tss_pkg::span_out_t data_q;
  logic               valid_q;

  // Crossing per edge: far x on a flat edge, else x0 +/- quotient
  always_comb begin
    if (data_i.la.flat) begin
      xa = data_i.la.x1;
    end else if (data_i.la.neg) begin
      xa = data_i.la.x0 - data_i.la.acc[W-1:0];
    end else begin
      xa = data_i.la.x0 + data_i.la.acc[W-1:0];
    end
    if (data_i.lb.flat) begin
      xb = data_i.lb.x1;
    end else if (data_i.lb.neg) begin
      xb = data_i.lb.x0 - data_i.lb.acc[W-1:0];
    end else begin
      xb = data_i.lb.x0 + data_i.lb.acc[W-1:0];
    end
  end

  // Order the ends and form the start address
  always_comb begin
    lo = (xb < xa) ? xb : xa;
    hi = (xb < xa) ? xa : xb;
    if (data_i.covered) begin
      data_d.covered       = 1'b1;
      data_d.left_x        = lo;
      data_d.right_x       = hi;
      data_d.start_address = data_i.addr_row + tss_pkg::AddrWidth'(lo);
    end else begin
      data_d = '0;
    end
  end

  // Output register
  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/triangle_scanline_span.sv =====
// Scanline span of a filled triangle. Each input transfer carries three vertices and a row;
// each output transfer gives whether the row is covered, the left and right ends of the span
// and its byte address (frame_base + row * row_stride + left_x, 16-bit wrap). Uncovered rows
// return all zero fields. The pipeline takes one item per clock unless stalled and returns one
// result per item in order, through one setup stage (sort and edge select), one multiply
// stage, one restoring-divide stage per quotient bit, and the output register. Registers are
// to be written over the config port only while the pipeline is empty; the block itself does
// not enforce this. cfg_ready_o is always high and unknown indexes are ignored.
module triangle_scanline_span (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tss_pkg::span_in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tss_pkg::span_out_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tss_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [tss_pkg::CfgDataWidth-1:0]     cfg_data_i
);

  logic [tss_pkg::AddrWidth-1:0]   frame_base_q;
  logic [tss_pkg::StrideWidth-1:0] row_stride_q;

  logic            setup_ready;
  logic            setup_valid;
  tss_pkg::setup_t setup_data;
  logic            mul_ready;
  logic            mul_valid;
  tss_pkg::div_t   mul_data;
  logic            div_ready;
  logic            div_valid;
  tss_pkg::div_t   div_data;
  logic            span_ready;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= tss_pkg::FrameBaseReset;
      row_stride_q <= tss_pkg::RowStrideReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tss_pkg::cfg_reg_e'(cfg_index_i))
        tss_pkg::CfgFrameBase: begin
          frame_base_q <= cfg_data_i[tss_pkg::AddrWidth-1:0];
        end
        tss_pkg::CfgRowStride: begin
          row_stride_q <= cfg_data_i[tss_pkg::StrideWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline
  assign in_stall_o = !setup_ready;

  tss_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (setup_ready),
    .data_i  (in_data_i),
    .valid_o (setup_valid),
    .ready_i (mul_ready),
    .data_o  (setup_data)
  );

  tss_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_base_i (frame_base_q),
    .row_stride_i (row_stride_q),
    .valid_i      (setup_valid),
    .ready_o      (mul_ready),
    .data_i       (setup_data),
    .valid_o      (mul_valid),
    .ready_i      (div_ready),
    .data_o       (mul_data)
  );

  tss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (div_ready),
    .data_i  (mul_data),
    .valid_o (div_valid),
    .ready_i (span_ready),
    .data_o  (div_data)
  );

  tss_span u_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (span_ready),
    .data_i  (div_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int PipeLatency   = tss_pkg::CoordWidth + 3;
  localparam int CoordMax      = (1 << tss_pkg::CoordWidth) - 1;
  localparam int LongHold      = 600;
  localparam int WatchdogLimit = 5000;
  localparam int PhaseItems    = 300;
  localparam int RandomPhases  = 5;

  // Indexes that map to no register
  localparam logic [tss_pkg::CfgIndexWidth-1:0] CfgUnusedLo = tss_pkg::CfgIndexWidth'(2);
  localparam logic [tss_pkg::CfgIndexWidth-1:0] CfgUnusedHi = tss_pkg::CfgIndexWidth'(15);

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  tss_pkg::span_in_t                 in_data_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  tss_pkg::span_out_t                out_data_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [tss_pkg::CfgIndexWidth-1:0] cfg_index_i;
  logic [tss_pkg::CfgDataWidth-1:0]  cfg_data_i;

  // Predictor copy of the registers and the spans still owed by the block
  logic [tss_pkg::AddrWidth-1:0]   pred_base   = tss_pkg::FrameBaseReset;
  logic [tss_pkg::StrideWidth-1:0] pred_stride = tss_pkg::RowStrideReset;
  tss_pkg::span_out_t              span_expect_q[$];

  int  n_errors    = 0;
  int  n_checked   = 0;
  int  n_covered   = 0;
  int  n_cfg       = 0;
  int  idle_cycles = 0;
  bit  gaps_on     = 1'b1;
  bit  stall_on    = 1'b1;
  bit  hold_req    = 1'b0;

  triangle_scanline_span uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Edge crossing at row y; a flat edge yields its far-end x
  function automatic int edge_x(input int x0, input int y0, input int x1, input int y1,
                                input int y);
    if (y0 == y1) return x1;
    return x0 + ((x1 - x0) * (y - y0)) / (y1 - y0);
  endfunction

  // Expected span for one triangle/row under the current registers
  function automatic tss_pkg::span_out_t predict_span(input tss_pkg::span_in_t it);
    int                 vx[3];
    int                 vy[3];
    int                 t, xa, xb, y, p;
    tss_pkg::span_out_t r;
    vx[0] = it.ax; vy[0] = it.ay;
    vx[1] = it.bx; vy[1] = it.by;
    vx[2] = it.cx; vy[2] = it.cy;
    y = it.row;
    r = '0;
    // stable y sort, one swap per pass
    for (p = 0; p < 4; p++) begin
      if (vy[0] > vy[1]) begin
        t = vx[0]; vx[0] = vx[1]; vx[1] = t;
        t = vy[0]; vy[0] = vy[1]; vy[1] = t;
      end else if (vy[1] > vy[2]) begin
        t = vx[1]; vx[1] = vx[2]; vx[2] = t;
        t = vy[1]; vy[1] = vy[2]; vy[2] = t;
      end
    end
    if (y < vy[0] || y > vy[2]) return r;
    if (y <= vy[1]) begin
      xa = edge_x(vx[0], vy[0], vx[1], vy[1], y);
      xb = edge_x(vx[0], vy[0], vx[2], vy[2], y);
    end else begin
      xa = edge_x(vx[2], vy[2], vx[1], vy[1], y);
      xb = edge_x(vx[2], vy[2], vx[0], vy[0], y);
    end
    if (xb < xa) begin
      t = xa; xa = xb; xb = t;
    end
    r.covered       = 1'b1;
    r.left_x        = tss_pkg::coord_t'(xa);
    r.right_x       = tss_pkg::coord_t'(xb);
    r.start_address = tss_pkg::AddrWidth'(int'(pred_base) + y * int'(pred_stride) +
                                          int'(r.left_x));
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random triangle; most rows fall inside the y range, some vertices share y
  function automatic tss_pkg::span_in_t rand_span();
    tss_pkg::span_in_t s;
    int                kind, lo, hi;
    s.ax = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    s.ay = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    s.bx = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    s.by = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    s.cx = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    s.cy = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    kind = $urandom_range(0, 9);
    case (kind)
      6: s.by = s.ay;
      7: s.cy = s.by;
      8: begin
        s.by = s.ay;
        s.cy = s.ay;
      end
      default: ;
    endcase
    lo = s.ay; hi = s.ay;
    if (s.by < lo) lo = s.by;
    if (s.cy < lo) lo = s.cy;
    if (s.by > hi) hi = s.by;
    if (s.cy > hi) hi = s.cy;
    if (kind == 9) s.row = tss_pkg::coord_t'($urandom_range(0, CoordMax));
    else           s.row = tss_pkg::coord_t'($urandom_range(lo, hi));
    return s;
  endfunction

  // One input transfer, preceded by an optional gap
  task automatic send_span(input tss_pkg::span_in_t item);
    int gap;
    gap = gaps_on ? rand_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    span_expect_q.push_back(predict_span(item));
  endtask

  task automatic send_tri(input int ax, input int ay, input int bx, input int by,
                          input int cx, input int cy, input int row);
    tss_pkg::span_in_t s;
    s.ax = tss_pkg::coord_t'(ax); s.ay = tss_pkg::coord_t'(ay);
    s.bx = tss_pkg::coord_t'(bx); s.by = tss_pkg::coord_t'(by);
    s.cx = tss_pkg::coord_t'(cx); s.cy = tss_pkg::coord_t'(cy);
    s.row = tss_pkg::coord_t'(row);
    send_span(s);
  endtask

  // Drop valid, let every owed span arrive, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (span_expect_q.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  // One config transfer; the predictor follows the same index decode
  task automatic write_reg(input logic [tss_pkg::CfgIndexWidth-1:0] idx,
                           input logic [tss_pkg::CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tss_pkg::CfgFrameBase)      pred_base   = data[tss_pkg::AddrWidth-1:0];
    else if (idx == tss_pkg::CfgRowStride) pred_stride = data[tss_pkg::StrideWidth-1:0];
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver stall pattern, with a long hold on request
  initial begin : rx_stall
    int  seg_left;
    int  hold_left;
    bit  seg_stall;
    seg_left  = 0;
    hold_left = 0;
    seg_stall = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold - 1;
        out_stall_i <= 1'b1;
      end else if (!stall_on) begin
        out_stall_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_stall = ($urandom_range(0, 2) == 0);
          if (seg_stall) seg_left = rand_gap() + 1;
          else           seg_left = $urandom_range(1, 10);
        end
        seg_left--;
        out_stall_i <= seg_stall;
      end
    end
  end

  // Compare each output transfer with the oldest owed span
  always @(posedge clk_i) begin
    tss_pkg::span_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (span_expect_q.size() == 0) begin
        $error("unexpected span transfer: %p", out_data_o);
        n_errors++;
      end else begin
        want = span_expect_q.pop_front();
        n_checked++;
        if (want.covered) n_covered++;
        if (out_data_o.covered !== want.covered) begin
          $error("covered: expected %0d, got %0d", want.covered, out_data_o.covered);
          n_errors++;
        end
        if (out_data_o.left_x !== want.left_x) begin
          $error("left_x: expected %0d, got %0d", want.left_x, out_data_o.left_x);
          n_errors++;
        end
        if (out_data_o.right_x !== want.right_x) begin
          $error("right_x: expected %0d, got %0d", want.right_x, out_data_o.right_x);
          n_errors++;
        end
        if (out_data_o.start_address !== want.start_address) begin
          $error("start_address: expected %0d, got %0d", want.start_address,
                 out_data_o.start_address);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $error("no transfer for %0d cycles", WatchdogLimit);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Geometry cases under the reset register values
  task automatic test_geometry();
    send_tri(0, 0, 0, 0, 0, 0, 0);                  // everything at the origin
    send_tri(127, 127, 127, 127, 127, 127, 127);    // everything at the far corner
    send_tri(10, 20, 60, 40, 100, 90, 5);           // row above the triangle
    send_tri(10, 20, 60, 40, 100, 90, 120);         // row below the triangle
    send_tri(10, 20, 60, 40, 100, 90, 20);          // top vertex row
    send_tri(10, 20, 60, 40, 100, 90, 40);          // middle vertex row
    send_tri(10, 20, 60, 40, 100, 90, 65);          // lower half
    send_tri(100, 90, 60, 40, 10, 20, 30);          // vertices in reverse y order
    send_tri(5, 30, 120, 30, 60, 100, 30);          // flat top edge
    send_tri(5, 30, 120, 30, 60, 100, 31);
    send_tri(60, 10, 0, 80, 127, 80, 80);           // flat bottom edge
    send_tri(20, 50, 90, 50, 50, 50, 50);           // all three on one row
    send_tri(127, 0, 0, 3, 127, 3, 1);              // negative slope, truncation
    send_tri(0, 0, 0, 127, 127, 127, 127);          // full-width span
    send_tri(90, 60, 30, 60, 70, 10, 40);           // tie on y, order kept
    wait_idle();
  endtask

  // Register extremes, masking of stride data and unused indexes
  task automatic test_registers();
    write_reg(tss_pkg::CfgFrameBase, '0);
    write_reg(tss_pkg::CfgRowStride, '0);
    send_tri(10, 0, 100, 127, 40, 64, 0);           // zero stride: the row adds nothing to the start
    send_tri(10, 0, 100, 127, 40, 64, 127);
    wait_idle();
    write_reg(tss_pkg::CfgFrameBase, 16'hFFFF);
    write_reg(tss_pkg::CfgRowStride, 16'h00FF);
    send_tri(127, 0, 127, 127, 127, 64, 127);       // address wraps at 16 bits
    send_tri(0, 0, 127, 127, 0, 127, 64);
    wait_idle();
    write_reg(tss_pkg::CfgRowStride, 16'hAB01);     // upper data bits dropped
    write_reg(tss_pkg::CfgFrameBase, 16'h0001);
    send_tri(3, 5, 70, 90, 120, 40, 50);
    wait_idle();
    write_reg(CfgUnusedLo, 16'h1234);               // ignored
    write_reg(CfgUnusedHi, 16'hFFFF);
    send_tri(3, 5, 70, 90, 120, 40, 60);
    send_tri(3, 5, 70, 90, 120, 40, 100);
    wait_idle();
  endtask

  // Random triangles across several register settings and idle patterns
  task automatic test_random();
    int ph, i, pick;
    for (ph = 0; ph < RandomPhases; ph++) begin
      write_reg(tss_pkg::CfgFrameBase, tss_pkg::CfgDataWidth'($urandom));
      pick = $urandom_range(0, 3);
      case (pick)
        0:       write_reg(tss_pkg::CfgRowStride, tss_pkg::CfgDataWidth'(0));
        1:       write_reg(tss_pkg::CfgRowStride, tss_pkg::CfgDataWidth'(255));
        default: write_reg(tss_pkg::CfgRowStride, tss_pkg::CfgDataWidth'($urandom));
      endcase
      for (i = 0; i < PhaseItems; i++) begin
        if (i % 100 == 0) begin
          gaps_on  = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        send_span(rand_span());
      end
      wait_idle();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Long receiver hold while the sender keeps offering; the pipeline backs up
  task automatic test_backpressure();
    int i;
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 100; i++) send_span(rand_span());
    gaps_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= tss_pkg::CfgFrameBase;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_geometry();
    test_registers();
    test_random();
    test_backpressure();

    if (span_expect_q.size() != 0) begin
      $error("%0d spans never arrived", span_expect_q.size());
      n_errors++;
    end
    $display("Checked %0d spans, %0d on covered rows, %0d outside the triangle,",
             n_checked, n_covered, n_checked - n_covered);
    $display("across %0d register writes including zero/max stride and unused indexes.",
             n_cfg);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
